>>> sv/sle_pkg.sv
// ----------------------------------------------------------------------------
// Sorted list engine package
// Shared types, codes and constants of the sorted list engine.
// ----------------------------------------------------------------------------
package sle_pkg;

  // Default number of cells in the chain.
  localparam int DEF_DEPTH = 64;

  // Fixed field widths.
  localparam int VAL_W = 32;
  localparam int POS_W = 7;

  typedef logic signed [VAL_W-1:0] val_t;

  // Commands carried on the input tuser.
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_DUMP   = 2'd3
  } cmd_t;

  // Result status carried on the output tuser.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  // Operation that every cell applies.
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_ROTATE = 2'd3
  } op_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_DUMP = 2'd2
  } state_t;

  // Control broadcast from the controller to all cells.
  typedef struct packed {
    op_t  op;
    logic capture;
    val_t key;
  } cell_ctl_t;

  // Summary returned from the chain to the controller.
  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] ins_pos;
    logic [POS_W-1:0] match_pos;
    val_t             head;
  } chain_stat_t;

endpackage

>>> sv/sle_cell.sv
// ----------------------------------------------------------------------------
// Sorted list cell
// Holds one entry, its compare flags against the key, and shifts with its
// neighbors on insert, remove and rotate.
// ----------------------------------------------------------------------------
module sle_cell (
  input  logic               clk,
  input  sle_pkg::cell_ctl_t ctl,
  input  logic               occ,        // this cell holds a valid entry
  input  logic               at_count,   // this cell is the first free one
  input  logic               last_occ,   // this cell holds the last valid entry
  input  sle_pkg::val_t      prev_entry,
  input  logic               prev_ge,
  input  sle_pkg::val_t      next_entry,
  input  sle_pkg::val_t      head_entry,
  output sle_pkg::val_t      entry,
  output logic               ge,
  output logic               eq
);
  import sle_pkg::*;

  // Compare flags are taken when an item is accepted.
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      ge <= occ && (entry >= ctl.key);
      eq <= occ && (entry == ctl.key);
    end
  end

  // Entry update: the whole chain moves together.
  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_INSERT: begin
        if (prev_ge) begin
          entry <= prev_entry;
        end else if (ge || at_count) begin
          entry <= ctl.key;
        end
      end
      OP_REMOVE: begin
        if (ge) begin
          entry <= next_entry;
        end
      end
      OP_ROTATE: begin
        entry <= last_occ ? head_entry : next_entry;
      end
      default: begin
        entry <= entry;
      end
    endcase
  end

endmodule

>>> sv/sle_chain.sv
// ----------------------------------------------------------------------------
// Sorted list cell chain
// A row of DEPTH cells with neighbor links, plus the encoders that turn the
// compare flags into an insert position and a first match position.
// ----------------------------------------------------------------------------
module sle_chain #(
  parameter int DEPTH = sle_pkg::DEF_DEPTH
) (
  input  logic                         clk,
  input  sle_pkg::cell_ctl_t           ctl,
  input  logic [$clog2(DEPTH+1)-1:0]   count,
  output sle_pkg::chain_stat_t         stat
);
  import sle_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  val_t entry_w   [DEPTH];
  logic ge_w      [DEPTH];
  logic eq_w      [DEPTH];
  logic ge_prev_w [DEPTH];
  logic eq_prev_w [DEPTH];

  // Row of cells, each linked to both neighbors.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    val_t prev_v;
    val_t next_v;
    logic prev_g;

    if (i == 0) begin : g_first
      assign prev_v       = '0;
      assign prev_g       = 1'b0;
      assign eq_prev_w[i] = 1'b0;
    end else begin : g_mid
      assign prev_v       = entry_w[i-1];
      assign prev_g       = ge_w[i-1];
      assign eq_prev_w[i] = eq_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_v = '0;
    end else begin : g_inner
      assign next_v = entry_w[i+1];
    end

    assign ge_prev_w[i] = prev_g;

    sle_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occ        (count > CNT_W'(i)),
      .at_count   (count == CNT_W'(i)),
      .last_occ   (count == CNT_W'(i + 1)),
      .prev_entry (prev_v),
      .prev_ge    (prev_g),
      .next_entry (next_v),
      .head_entry (entry_w[0]),
      .entry      (entry_w[i]),
      .ge         (ge_w[i]),
      .eq         (eq_w[i])
    );
  end

  logic [POS_W-1:0] ins_enc;
  logic [POS_W-1:0] match_enc;
  logic             any_ge;
  logic             any_eq;

  // The list is sorted, so the flags form one run: its first cell is a
  // rising edge against the left neighbor, and the OR of indexes encodes it.
  always_comb begin
    ins_enc   = '0;
    match_enc = '0;
    any_ge    = 1'b0;
    any_eq    = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      any_ge = any_ge | ge_w[i];
      any_eq = any_eq | eq_w[i];
      if (ge_w[i] && !ge_prev_w[i]) begin
        ins_enc = ins_enc | POS_W'(i);
      end
      if (eq_w[i] && !eq_prev_w[i]) begin
        match_enc = match_enc | POS_W'(i);
      end
    end
  end

  // With no entry at or above the key the value goes at the end.
  assign stat.found     = any_eq;
  assign stat.ins_pos   = any_ge ? ins_enc : POS_W'(count);
  assign stat.match_pos = match_enc;
  assign stat.head      = entry_w[0];

endmodule

>>> sv/sorted_list_engine.sv
// ----------------------------------------------------------------------------
// Sorted list engine
// Keeps up to DEPTH signed values in ascending order in a chain of cells and
// serves insert, remove, search and dump commands.
// ----------------------------------------------------------------------------
//  Channel  Dir  Signals                   Contents
//  s_*      in   tvalid tready tdata tuser tdata: value[31:0]; tuser: cmd[1:0]
//  m_*      out  tvalid tready tdata tuser tdata: result_value[31:0],
//                tlast                     position[38:32], zero pad[39];
//                                          tuser: status[1:0]; tlast: last
//
// Insert, remove and search: the accept cycle captures every cell's compare
// flags, and the EXEC state, once the output is free, shifts the chain and
// writes the result. A dump emits one result per stored entry, since the
// chain rotates by one cell per result transfer.
// Reset clears the entry count and the output valid; the entries themselves
// are not cleared. A stalled output holds the controller in its result cycle.
// ----------------------------------------------------------------------------
module sorted_list_engine #(
  parameter int DEPTH = sle_pkg::DEF_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // value[31:0]
  input  logic [1:0]  s_tuser,   // cmd[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // result_value[31:0], position[38:32], pad[39]
  output logic [1:0]  m_tuser,   // status[1:0]
  output logic        m_tlast
);
  import sle_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [IDX_W-1:0] didx;
  logic [IDX_W-1:0] didx_next;
  cmd_t             cmd_reg;
  val_t             key_reg;

  cell_ctl_t        ctl;
  chain_stat_t      stat;
  op_t              op;
  logic             accept;
  logic             out_free;
  logic             load;
  val_t             out_val;
  logic [POS_W-1:0] out_pos;
  status_t          out_st;
  logic             out_last;
  logic             is_full;
  logic             dump_last;

  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign is_full   = (count == CNT_W'(DEPTH));
  assign dump_last = ((CNT_W'(didx) + CNT_W'(1)) == count);

  // Broadcast to the cells: the raw input key during the accept cycle.
  assign ctl.op      = op;
  assign ctl.capture = accept;
  assign ctl.key     = (state == S_IDLE) ? val_t'(s_tdata) : key_reg;

  sle_chain #(
    .DEPTH (DEPTH)
  ) u_chain (
    .clk   (clk),
    .ctl   (ctl),
    .count (count),
    .stat  (stat)
  );

  // Next state, chain operation and result selection.
  always_comb begin
    state_next = state;
    count_next = count;
    didx_next  = didx;
    op         = OP_HOLD;
    load       = 1'b0;
    out_val    = key_reg;
    out_pos    = '0;
    out_st     = ST_OK;
    out_last   = 1'b1;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_next = S_IDLE;
          unique case (cmd_reg)
            CMD_INSERT: begin
              load    = 1'b1;
              out_pos = stat.ins_pos;
              if (is_full) begin
                out_st = ST_FULL;
              end else begin
                op         = OP_INSERT;
                count_next = count + CNT_W'(1);
              end
            end
            CMD_REMOVE: begin
              load = 1'b1;
              if (stat.found) begin
                op         = OP_REMOVE;
                count_next = count - CNT_W'(1);
                out_pos    = stat.match_pos;
              end else begin
                out_st = ST_NOTFOUND;
              end
            end
            CMD_SEARCH: begin
              // A hit stores a value equal to the key.
              load = 1'b1;
              if (stat.found) begin
                out_pos = stat.match_pos;
              end else begin
                out_st = ST_NOTFOUND;
              end
            end
            CMD_DUMP: begin
              if (count == '0) begin
                load    = 1'b1;
                out_val = '0;
                out_st  = ST_EMPTY;
              end else begin
                didx_next  = '0;
                state_next = S_DUMP;
              end
            end
          endcase
        end
      end
      S_DUMP: begin
        // Emit the head cell, then rotate the list left by one.
        if (out_free) begin
          load     = 1'b1;
          out_val  = stat.head;
          out_pos  = POS_W'(didx);
          out_last = dump_last;
          op       = OP_ROTATE;
          if (dump_last) begin
            state_next = S_IDLE;
          end else begin
            didx_next = didx + IDX_W'(1);
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Command, key, dump index and result registers.
  always_ff @(posedge clk) begin
    didx <= didx_next;
    if (accept) begin
      cmd_reg <= cmd_t'(s_tuser);
      key_reg <= val_t'(s_tdata);
    end
    if (load) begin
      m_tdata <= {1'b0, out_pos, out_val};
      m_tuser <= out_st;
      m_tlast <= out_last;
    end
  end

endmodule

>>> sv/sle_checker.sv
// ----------------------------------------------------------------------------
// Sorted list engine checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module sle_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        m_tlast
);
  import sle_pkg::*;

  // No result is offered in the cycle after reset.
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result offered right after reset");

  // A stalled result keeps its contents.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("stalled result changed");

  // Only dump entries can be non-final, and they always carry status ok.
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != ST_OK) |-> m_tlast)
    else $error("non-ok result is not the final one");

  // Misses and empty dumps report position zero.
  a_miss_pos: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && ((m_tuser == ST_NOTFOUND) || (m_tuser == ST_EMPTY))
      |-> (m_tdata[38:32] == '0))
    else $error("miss or empty result with nonzero position");

endmodule

bind sorted_list_engine sle_checker u_sle_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
